[hw/rtl/bal_pkg.sv]
package bal_pkg;

	localparam int CAPACITY_DEF   = 256;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int REQ_W    = 3;
	localparam int STATUS_W = 3;

	localparam logic [REQ_W-1:0] REQ_INSERT       = 3'd0;
	localparam logic [REQ_W-1:0] REQ_GET          = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FIND         = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REMOVE_AT    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_REMOVE_VALUE = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CLEAR        = 3'd5;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_POS   = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

	// command broadcast from the controller to every cell
	typedef struct packed {
		logic ins;
		logic del;
		logic get_mode;
	} bal_cmd_t;

endpackage

[hw/rtl/bounded_array_list_engine_top.sv]
// ordered list of up to CAPACITY words held in a row of cells, one entry per cell
// request channel: req_valid / req_stall with req_type, position, data_value;
// a word is taken when req_valid is high and req_stall is low
// response channel: rsp_valid / rsp_stall with status, read_value,
// found_position and entry_count; one response word per request word
// insert, remove_at, clear and unknown types go straight to the apply state;
// all cells shift toward or away from the insert / remove point together
// get, find and remove_value first scan the chain; a result packet moves
// one cell per cycle down the chain so the lowest matching position wins
// one request is in flight at a time; req_stall is high from accept until the
// response is loaded into the output register
// a finished response waits in the output register while rsp_stall is high;
// the next request is still accepted but is not applied until the register frees
// reset clears the entry count and the handshake state; stored entries are not
// cleared and are never read before being written
module bounded_array_list_engine_top #(
	parameter int CAPACITY   = bal_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = bal_pkg::DATA_WIDTH_DEF,
	parameter int CW         = $clog2(CAPACITY + 1),
	parameter int IW         = $clog2(CAPACITY)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [bal_pkg::REQ_W-1:0]     req_type,
	input  logic [CW-1:0]                 position,
	input  logic [DATA_WIDTH-1:0]         data_value,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [bal_pkg::STATUS_W-1:0]  status,
	output logic [DATA_WIDTH-1:0]         read_value,
	output logic [IW-1:0]                 found_position,
	output logic [CW-1:0]                 entry_count
);
	import bal_pkg::*;

	bal_cmd_t              cmd;
	logic [CW-1:0]         pos_bus;
	logic [DATA_WIDTH-1:0] key_bus;
	logic [CW-1:0]         count_bus;

	logic [DATA_WIDTH-1:0] entry_w  [CAPACITY];
	logic                  pk_hit_w [CAPACITY];
	logic [DATA_WIDTH-1:0] pk_val_w [CAPACITY];
	logic [IW-1:0]         pk_idx_w [CAPACITY];

	bal_ctrl #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH),
		.CW         (CW),
		.IW         (IW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req_type       (req_type),
		.position       (position),
		.data_value     (data_value),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.read_value     (read_value),
		.found_position (found_position),
		.entry_count    (entry_count),
		.cmd            (cmd),
		.pos_bus        (pos_bus),
		.key_bus        (key_bus),
		.count_bus      (count_bus),
		.last_hit       (pk_hit_w[CAPACITY-1]),
		.last_val       (pk_val_w[CAPACITY-1]),
		.last_idx       (pk_idx_w[CAPACITY-1])
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;
		logic                  hit_in_w;
		logic [DATA_WIDTH-1:0] val_in_w;
		logic [IW-1:0]         idx_in_w;

		if (i == 0) begin : g_first
			assign left_w   = '0;
			assign hit_in_w = 1'b0;
			assign val_in_w = '0;
			assign idx_in_w = '0;
		end else begin : g_mid
			assign left_w   = entry_w[i-1];
			assign hit_in_w = pk_hit_w[i-1];
			assign val_in_w = pk_val_w[i-1];
			assign idx_in_w = pk_idx_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = entry_w[i+1];
		end

		bal_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CW         (CW),
			.IW         (IW),
			.IDX        (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.pos         (pos_bus),
			.key         (key_bus),
			.count       (count_bus),
			.left_entry  (left_w),
			.right_entry (right_w),
			.entry       (entry_w[i]),
			.pk_hit_in   (hit_in_w),
			.pk_val_in   (val_in_w),
			.pk_idx_in   (idx_in_w),
			.pk_hit      (pk_hit_w[i]),
			.pk_val      (pk_val_w[i]),
			.pk_idx      (pk_idx_w[i])
		);
	end

endmodule

[hw/rtl/bal_cell.sv]
module bal_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int CW         = 9,
	parameter int IW         = 8,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bal_pkg::bal_cmd_t     cmd,
	input  logic [CW-1:0]         pos,
	input  logic [DATA_WIDTH-1:0] key,
	input  logic [CW-1:0]         count,
	input  logic [DATA_WIDTH-1:0] left_entry,
	input  logic [DATA_WIDTH-1:0] right_entry,
	output logic [DATA_WIDTH-1:0] entry,
	input  logic                  pk_hit_in,
	input  logic [DATA_WIDTH-1:0] pk_val_in,
	input  logic [IW-1:0]         pk_idx_in,
	output logic                  pk_hit,
	output logic [DATA_WIDTH-1:0] pk_val,
	output logic [IW-1:0]         pk_idx
);
	import bal_pkg::*;

	localparam logic [CW-1:0] IDX_C  = CW'(IDX);
	localparam logic [IW-1:0] IDX_IW = IW'(IDX);

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  pk_hit_q;
	logic [DATA_WIDTH-1:0] pk_val_q;
	logic [IW-1:0]         pk_idx_q;
	logic                  in_list;
	logic                  self_hit;

	assign entry   = entry_q;
	assign pk_hit  = pk_hit_q;
	assign pk_val  = pk_val_q;
	assign pk_idx  = pk_idx_q;
	assign in_list = IDX_C < count;

	always_comb begin
		if (cmd.get_mode) begin
			self_hit = in_list && (IDX_C == pos);
		end else begin
			self_hit = in_list && (entry_q == key);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (IDX_C > pos) begin
				entry_q <= left_entry;
			end else if (IDX_C == pos) begin
				entry_q <= key;
			end
		end else if (cmd.del) begin
			if (IDX_C >= pos) begin
				entry_q <= right_entry;
			end
		end
	end

	// lower positions win: an earlier hit passes through untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_hit_q <= 1'b0;
		end else begin
			pk_hit_q <= pk_hit_in || self_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (pk_hit_in) begin
			pk_val_q <= pk_val_in;
			pk_idx_q <= pk_idx_in;
		end else begin
			pk_val_q <= entry_q;
			pk_idx_q <= IDX_IW;
		end
	end

endmodule

[hw/rtl/bal_ctrl.sv]
module bal_ctrl #(
	parameter int CAPACITY   = 256,
	parameter int DATA_WIDTH = 32,
	parameter int CW         = 9,
	parameter int IW         = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [bal_pkg::REQ_W-1:0]     req_type,
	input  logic [CW-1:0]                 position,
	input  logic [DATA_WIDTH-1:0]         data_value,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [bal_pkg::STATUS_W-1:0]  status,
	output logic [DATA_WIDTH-1:0]         read_value,
	output logic [IW-1:0]                 found_position,
	output logic [CW-1:0]                 entry_count,
	output bal_pkg::bal_cmd_t             cmd,
	output logic [CW-1:0]                 pos_bus,
	output logic [DATA_WIDTH-1:0]         key_bus,
	output logic [CW-1:0]                 count_bus,
	input  logic                          last_hit,
	input  logic [DATA_WIDTH-1:0]         last_val,
	input  logic [IW-1:0]                 last_idx
);
	import bal_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;

	logic [1:0]            state_q;
	logic [REQ_W-1:0]      req_q;
	logic [CW-1:0]         pos_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic [CW-1:0]         count_q;
	logic [IW-1:0]         scan_cnt_q;
	logic                  rsp_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [DATA_WIDTH-1:0] read_value_q;
	logic [IW-1:0]         found_q;

	logic                  accept;
	logic                  fire;
	logic                  needs_scan;
	logic [STATUS_W-1:0]   status_c;
	logic [DATA_WIDTH-1:0] rd_c;
	logic [IW-1:0]         fp_c;
	logic [CW-1:0]         count_c;
	logic                  do_ins;
	logic                  do_del;

	assign req_stall      = state_q != ST_IDLE;
	assign accept         = req_valid && !req_stall;
	assign fire           = (state_q == ST_APPLY) && (!rsp_valid_q || !rsp_stall);
	assign needs_scan     = (req_type == REQ_GET) || (req_type == REQ_FIND)
		|| (req_type == REQ_REMOVE_VALUE);

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign read_value     = read_value_q;
	assign found_position = found_q;
	assign entry_count    = count_q;

	assign cmd.ins      = fire && do_ins;
	assign cmd.del      = fire && do_del;
	assign cmd.get_mode = req_q == REQ_GET;
	assign pos_bus      = (req_q == REQ_REMOVE_VALUE) ? CW'(last_idx) : pos_q;
	assign key_bus      = key_q;
	assign count_bus    = count_q;

	always_comb begin
		status_c = STATUS_OK;
		rd_c     = '0;
		fp_c     = '0;
		count_c  = count_q;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		case (req_q)
			REQ_INSERT: begin
				if (pos_q > count_q) begin
					status_c = STATUS_BAD_POS;
				end else if (count_q == CW'(CAPACITY)) begin
					status_c = STATUS_FULL;
				end else begin
					do_ins  = 1'b1;
					count_c = count_q + 1'b1;
				end
			end
			REQ_GET: begin
				if (last_hit) begin
					rd_c = last_val;
				end else begin
					status_c = STATUS_BAD_POS;
				end
			end
			REQ_FIND: begin
				if (last_hit) begin
					fp_c = last_idx;
				end else begin
					status_c = STATUS_NOT_FOUND;
				end
			end
			REQ_REMOVE_AT: begin
				if (count_q == '0) begin
					status_c = STATUS_EMPTY;
				end else if (pos_q >= count_q) begin
					status_c = STATUS_BAD_POS;
				end else begin
					do_del  = 1'b1;
					count_c = count_q - 1'b1;
				end
			end
			REQ_REMOVE_VALUE: begin
				if (last_hit) begin
					do_del  = 1'b1;
					count_c = count_q - 1'b1;
				end else begin
					status_c = STATUS_NOT_FOUND;
				end
			end
			REQ_CLEAR: begin
				count_c = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= REQ_CLEAR;
			count_q     <= '0;
			scan_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q      <= req_type;
						scan_cnt_q <= '0;
						state_q    <= needs_scan ? ST_SCAN : ST_APPLY;
					end
				end
				ST_SCAN: begin
					// last cell holds the answer once the chain has filled
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (scan_cnt_q == IW'(CAPACITY - 1)) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (fire) begin
						count_q <= count_c;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= position;
			key_q <= data_value;
		end
		if (fire) begin
			status_q     <= status_c;
			read_value_q <= rd_c;
			found_q      <= fp_c;
		end
	end

endmodule
